>>> rtl/csrs_pkg.sv
// shared types and constants for the csr sparse store and lookup block
`timescale 1ns / 1ps
`default_nettype none
package csrs_pkg;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLUMNS  = 64;
    localparam int MAX_NONZEROS = 1024;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 64;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 7;
    localparam int CFG_IW   = 1;

    // derived widths
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int COLC_W  = $clog2(MAX_COLUMNS + 1);
    localparam int FILL_W  = $clog2(MAX_NONZEROS + 1);
    localparam int ELEM_AW = $clog2(MAX_NONZEROS);
    localparam int PTR_AW  = $clog2(MAX_ROWS);
    localparam int ELEM_W  = VALUE_W + IDX_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_BAD_ROW  = 3'd2,
        ST_ACCEPTED = 3'd3,
        ST_FULL     = 3'd4,
        ST_COMPLETE = 3'd5
    } t_status;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ROW_COUNT    = 1'd0,
        CFG_COLUMN_COUNT = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PTR_HI,
        S_PTR_LO,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0]  rows;
        logic [COLC_W-1:0] cols;
        logic              restart;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [ELEM_AW-1:0] waddr;
        logic [ELEM_W-1:0]  wdata;
        logic [ELEM_AW-1:0] raddr;
    } t_elem_req;

    typedef struct packed {
        logic              we;
        logic [PTR_AW-1:0] waddr;
        logic [FILL_W-1:0] wdata;
        logic [PTR_AW-1:0] raddr;
    } t_ptr_req;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/csrs_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module csrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/csrs_ctrl.sv
// sequencer: build counters, row pointer fetch and row scan
`timescale 1ns / 1ps
`default_nettype none
module csrs_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire csrs_pkg::t_cfg                i_cfg,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [csrs_pkg::OP_W-1:0]     i_op,
    input  wire logic [csrs_pkg::VALUE_W-1:0]  i_element_bits,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_column_index,
    input  wire logic                          i_out_free,
    output csrs_pkg::t_result                  o_res,
    output csrs_pkg::t_elem_req                o_elem_req,
    input  wire logic [csrs_pkg::ELEM_W-1:0]   i_elem_rdata,
    output csrs_pkg::t_ptr_req                 o_ptr_req,
    input  wire logic [csrs_pkg::FILL_W-1:0]   i_ptr_rdata
);
    import csrs_pkg::*;

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_build_row, n_build_row;
    logic [COL_W-1:0]   r_build_col, n_build_col;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]   r_rq, n_rq;
    logic [IDX_W-1:0]   r_cq, n_cq;
    logic [FILL_W-1:0]  r_stop, n_stop;
    logic [ELEM_AW-1:0] r_addr, n_addr;
    logic [VALUE_W-1:0] r_res_value, n_res_value;
    t_status            r_res_status, n_res_status;

    t_op                op;
    logic               accept;
    logic               build_done;
    logic               nonzero;
    logic               room;
    logic               store;
    logic               load_go;
    logic [FILL_W-1:0]  fill_load;
    logic [COLC_W-1:0]  col_next;
    logic               row_end;
    logic               bad_row;
    logic               col_out;
    logic               scan_go;
    logic [FILL_W-1:0]  start;
    logic               empty;
    logic               hit;
    logic               last;

    assign op         = t_op'(i_op);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign build_done = r_build_row >= i_cfg.rows;
    // +0 and -0 both count as zero
    assign nonzero    = |i_element_bits[VALUE_W-2:0];
    assign room       = r_fill < FILL_W'(MAX_NONZEROS);
    assign store      = nonzero && room;
    assign load_go    = accept && (op == OP_LOAD) && !build_done;
    assign fill_load  = store ? r_fill + FILL_W'(1) : r_fill;
    assign col_next   = COLC_W'(r_build_col) + COLC_W'(1);
    assign row_end    = col_next >= i_cfg.cols;
    assign bad_row    = (32'(i_row_index) >= 32'(r_build_row))
                     || (32'(i_row_index) >= 32'(i_cfg.rows))
                     || (32'(i_row_index) >= MAX_ROWS);
    assign col_out    = 32'(i_column_index) >= 32'(i_cfg.cols);
    assign scan_go    = !bad_row && !col_out;
    // row zero always starts at entry zero
    assign start      = (r_rq == '0) ? '0 : i_ptr_rdata;
    assign empty      = start >= r_stop;
    assign hit        = i_elem_rdata[ELEM_W-1 -: IDX_W] == r_cq;
    assign last       = (FILL_W'(r_addr) + FILL_W'(1)) >= r_stop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((op == OP_LOOKUP) && scan_go) begin
                        n_state = S_PTR_HI;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_PTR_HI: n_state = S_PTR_LO;
            S_PTR_LO: n_state = empty ? S_EMIT : S_SCAN;
            S_SCAN: begin
                if (hit || last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: handshake, memory ports, result
    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_elem_req.we    = load_go && store;
        o_elem_req.waddr = r_fill[ELEM_AW-1:0];
        o_elem_req.wdata = {IDX_W'(r_build_col), i_element_bits};
        o_elem_req.raddr = r_addr;
        o_ptr_req.we     = load_go && row_end;
        // pointer entry r holds the start of row r+1
        o_ptr_req.waddr  = r_build_row[PTR_AW-1:0];
        o_ptr_req.wdata  = fill_load;
        o_ptr_req.raddr  = r_rq[PTR_AW-1:0];
        o_res.valid      = 1'b0;
        o_res.value      = r_res_value;
        o_res.status     = r_res_status;
        case (r_state)
            S_IDLE:   o_ptr_req.raddr  = i_row_index[PTR_AW-1:0];
            S_PTR_HI: o_ptr_req.raddr  = r_rq[PTR_AW-1:0] - PTR_AW'(1);
            S_PTR_LO: o_elem_req.raddr = start[ELEM_AW-1:0];
            S_SCAN:   o_elem_req.raddr = r_addr + ELEM_AW'(1);
            S_EMIT:   o_res.valid      = i_out_free;
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_build_row  = r_build_row;
        n_build_col  = r_build_col;
        n_fill       = r_fill;
        n_rq         = r_rq;
        n_cq         = r_cq;
        n_stop       = r_stop;
        n_addr       = r_addr;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rq         = i_row_index;
                    n_cq         = i_column_index;
                    n_res_value  = '0;
                    n_res_status = ST_ACCEPTED;
                    case (op)
                        OP_LOAD: begin
                            if (build_done) begin
                                n_res_status = ST_COMPLETE;
                            end else begin
                                if (nonzero && !room) begin
                                    n_res_status = ST_FULL;
                                end
                                n_fill = fill_load;
                                if (row_end) begin
                                    n_build_col = '0;
                                    n_build_row = r_build_row + ROW_W'(1);
                                end else begin
                                    n_build_col = col_next[COL_W-1:0];
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            n_res_status = bad_row ? ST_BAD_ROW : ST_ABSENT;
                        end
                        OP_RESTART: begin
                            n_build_row = '0;
                            n_build_col = '0;
                            n_fill      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PTR_HI: n_stop = i_ptr_rdata;
            S_PTR_LO: n_addr = start[ELEM_AW-1:0];
            S_SCAN: begin
                if (hit) begin
                    n_res_status = ST_FOUND;
                    n_res_value  = i_elem_rdata[VALUE_W-1:0];
                end else begin
                    n_addr = r_addr + ELEM_AW'(1);
                end
            end
            default: begin
            end
        endcase
        // a config write restarts the build
        if (i_cfg.restart) begin
            n_build_row = '0;
            n_build_col = '0;
            n_fill      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_build_row <= '0;
            r_build_col <= '0;
            r_fill      <= '0;
        end else begin
            r_state     <= n_state;
            r_build_row <= n_build_row;
            r_build_col <= n_build_col;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rq         <= n_rq;
        r_cq         <= n_cq;
        r_stop       <= n_stop;
        r_addr       <= n_addr;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
    end

endmodule
`default_nettype wire

>>> rtl/csr_sparse_store_and_lookup.sv
// top level: config registers, element and row pointer memories, output register
// a load, restart, unused op, bad row or out-of-range column goes straight to the result;
//   a lookup reads two row pointers, then scans up to k stored entries (k <= 64, one
//   element memory read per cycle) until a column match or the end of the row
// one item in flight: the next input beat is taken only once the result is registered,
//   and a stalled output register holds it back
// reset: synchronous; build cleared at once (no memory clearing), both counts 64
`timescale 1ns / 1ps
`default_nettype none
module csr_sparse_store_and_lookup (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [csrs_pkg::OP_W-1:0]     i_op,
    input  wire logic [csrs_pkg::VALUE_W-1:0]  i_element_bits,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_column_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [csrs_pkg::VALUE_W-1:0]       o_value_bits,
    output logic [csrs_pkg::STATUS_W-1:0]      o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [csrs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [csrs_pkg::CFG_W-1:0]    i_cfg_data
);
    import csrs_pkg::*;

    logic [CFG_W-1:0]    r_row_count;
    logic [CFG_W-1:0]    r_column_count;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [STATUS_W-1:0] r_out_status;

    t_cfg                cfg;
    t_result             res;
    t_elem_req           elem_req;
    t_ptr_req            ptr_req;
    logic [ELEM_W-1:0]   elem_rdata;
    logic [FILL_W-1:0]   ptr_rdata;
    logic                out_free;

    // effective counts clamped to 1..max
    always_comb begin
        if (r_row_count == '0) begin
            cfg.rows = ROW_W'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            cfg.rows = ROW_W'(MAX_ROWS);
        end else begin
            cfg.rows = ROW_W'(r_row_count);
        end
        if (r_column_count == '0) begin
            cfg.cols = COLC_W'(1);
        end else if (32'(r_column_count) > MAX_COLUMNS) begin
            cfg.cols = COLC_W'(MAX_COLUMNS);
        end else begin
            cfg.cols = COLC_W'(r_column_count);
        end
        cfg.restart = i_cfg_we;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= CFG_W'(MAX_ROWS);
            r_column_count <= CFG_W'(MAX_COLUMNS);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_value  <= res.value;
            r_out_status <= res.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value_bits = r_out_value;
    assign o_status     = r_out_status;

    csrs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_element_bits (i_element_bits),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_out_free     (out_free),
        .o_res          (res),
        .o_elem_req     (elem_req),
        .i_elem_rdata   (elem_rdata),
        .o_ptr_req      (ptr_req),
        .i_ptr_rdata    (ptr_rdata)
    );

    // column index and value of every kept element
    csrs_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_NONZEROS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_req.we),
        .i_waddr (elem_req.waddr),
        .i_wdata (elem_req.wdata),
        .i_raddr (elem_req.raddr),
        .o_rdata (elem_rdata)
    );

    // end pointer of each completed row
    csrs_ram #(
        .WIDTH (FILL_W),
        .DEPTH (MAX_ROWS)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_req.we),
        .i_waddr (ptr_req.waddr),
        .i_wdata (ptr_req.wdata),
        .i_raddr (ptr_req.raddr),
        .o_rdata (ptr_rdata)
    );

endmodule
`default_nettype wire

>>> rtl/csrs_checker.sv
// port-level assertions for the csr sparse store and lookup block
`timescale 1ns / 1ps
`default_nettype none
module csrs_assert (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_ready,
    input  wire logic [csrs_pkg::OP_W-1:0]     i_op,
    input  wire logic [csrs_pkg::VALUE_W-1:0]  i_element_bits,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_column_index,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [csrs_pkg::VALUE_W-1:0]  o_value_bits,
    input  wire logic [csrs_pkg::STATUS_W-1:0] o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [csrs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [csrs_pkg::CFG_W-1:0]    i_cfg_data
);
    import csrs_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_value_bits) && $stable(o_status))
        else $error("result beat changed while stalled");

    // only a found lookup carries a value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_FOUND) |-> o_value_bits == '0)
        else $error("nonzero value on a result that is not found");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // a new result is never produced in the cycle after the block was idle
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without work in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind csr_sparse_store_and_lookup csrs_assert u_csrs_assert (.*);
`default_nettype wire

>>> test/csrs_checker.sv
// checker for the csr sparse store: predicts each answer and compares it with the output beats
`timescale 1ns / 1ps
module csrs_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_ready,
    input  wire logic [csrs_pkg::OP_W-1:0]     i_op,
    input  wire logic [csrs_pkg::VALUE_W-1:0]  i_element_bits,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [csrs_pkg::IDX_W-1:0]    i_column_index,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [csrs_pkg::VALUE_W-1:0]  o_value_bits,
    input  wire logic [csrs_pkg::STATUS_W-1:0] o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [csrs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [csrs_pkg::CFG_W-1:0]    i_cfg_data,
    output int                                 o_errors
);
    import csrs_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_answer;

    // shadow of the compressed store
    logic [VALUE_W-1:0] val_mem [MAX_NONZEROS];
    logic [IDX_W-1:0]   col_mem [MAX_NONZEROS];
    logic [FILL_W-1:0]  row_start [0:MAX_ROWS];
    logic [ROW_W-1:0]   build_row;
    logic [COLC_W-1:0]  build_col;
    logic [FILL_W-1:0]  fill;
    logic [CFG_W-1:0]   row_cnt;
    logic [CFG_W-1:0]   col_cnt;

    t_answer answer_q [$];
    int      fail_count = 0;

    assign o_errors = fail_count;

    function automatic int eff_count(input logic [CFG_W-1:0] v, input int maxv);
        if (v == '0) return 1;
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function automatic void clear_build();
        build_row    = '0;
        build_col    = '0;
        fill         = '0;
        row_start[0] = '0;
    endfunction

    function automatic t_answer sparse_answer(input logic [OP_W-1:0] op,
                                              input logic [VALUE_W-1:0] bits,
                                              input logic [IDX_W-1:0] rq,
                                              input logic [IDX_W-1:0] cq);
        t_answer a;
        int      rows;
        int      cols;
        int      start;
        int      stop;
        int      i;
        bit      hit;
        a.value  = '0;
        a.status = ST_ACCEPTED;
        rows     = eff_count(row_cnt, MAX_ROWS);
        cols     = eff_count(col_cnt, MAX_COLUMNS);
        hit      = 1'b0;
        if (op == OP_LOAD) begin
            if (int'(build_row) >= rows) begin
                a.status = ST_COMPLETE;
            end else begin
                // both signed zeros are dropped without touching the store
                if (bits[VALUE_W-2:0] != '0) begin
                    if (int'(fill) < MAX_NONZEROS) begin
                        val_mem[fill] = bits;
                        col_mem[fill] = build_col[IDX_W-1:0];
                        fill = fill + 1'b1;
                    end else begin
                        a.status = ST_FULL;
                    end
                end
                build_col = build_col + 1'b1;
                if (int'(build_col) >= cols) begin
                    build_col = '0;
                    build_row = build_row + 1'b1;
                    if (int'(build_row) <= MAX_ROWS) row_start[build_row] = fill;
                end
            end
        end else if (op == OP_LOOKUP) begin
            if (int'(rq) >= int'(build_row) || int'(rq) >= rows) begin
                a.status = ST_BAD_ROW;
            end else begin
                start = int'(row_start[rq]);
                stop  = int'(row_start[int'(rq) + 1]);
                if (stop > int'(fill)) stop = int'(fill);
                a.status = ST_ABSENT;
                for (i = start; i < stop && !hit; i++) begin
                    if (col_mem[i] == cq && int'(cq) < cols) begin
                        a.value  = val_mem[i];
                        a.status = ST_FOUND;
                        hit      = 1'b1;
                    end
                end
            end
        end else if (op == OP_RESTART) begin
            clear_build();
        end
        return a;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            row_cnt = CFG_W'(MAX_ROWS);
            col_cnt = CFG_W'(MAX_COLUMNS);
            clear_build();
            answer_q.delete();
        end else begin
            // a register write also restarts the build
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ROW_COUNT) row_cnt = i_cfg_data;
                else col_cnt = i_cfg_data;
                clear_build();
            end
            if (i_in_valid && o_in_ready) begin
                answer_q.push_back(sparse_answer(i_op, i_element_bits, i_row_index,
                                                 i_column_index));
            end
            if (o_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    $error("output beat with no answer pending: value_bits %h status %0d",
                           o_value_bits, o_status);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_value_bits !== want.value) begin
                        $error("value_bits: expected %h, got %h", want.value, o_value_bits);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> test/tb.sv
// testbench top: drives loads, lookups and restarts through several matrix shapes
`timescale 1ns / 1ps
module tb;
    import csrs_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HALF_PERIOD   = 6;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_BEATS   = 14;
    localparam int RANDOM_PHASES = 12;
    localparam int DRAIN_CYCLES  = 70;
    localparam int FILL_ROWS     = 3;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op           = '0;
    logic [VALUE_W-1:0]  i_element_bits = '0;
    logic [IDX_W-1:0]    i_row_index    = '0;
    logic [IDX_W-1:0]    i_column_index = '0;
    logic                o_out_valid;
    logic                i_out_ready    = 1'b0;
    logic [VALUE_W-1:0]  o_value_bits;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_we       = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index    = '0;
    logic [CFG_W-1:0]    i_cfg_data     = '0;

    int errors;
    int sent_cnt     = 0;
    int got_cnt      = 0;
    int quiet_cycles = 0;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int rows_eff     = MAX_ROWS;
    int cols_eff     = MAX_COLUMNS;
    int loads_since_restart = 0;
    int shapes_run   = 0;

    csr_sparse_store_and_lookup u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_element_bits (i_element_bits),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value_bits   (o_value_bits),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    csrs_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_element_bits (i_element_bits),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value_bits   (o_value_bits),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) got_cnt <= got_cnt + 1;
    end

    // no beat on either side for too long means the block is stuck
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] bits,
                             input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_element_bits <= bits;
        i_row_index    <= row;
        i_column_index <= col;
        do @(posedge i_clk); while (!o_in_ready);
        sent_cnt++;
        if (op == OP_LOAD) loads_since_restart++;
        else if (op == OP_RESTART) loads_since_restart = 0;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (got_cnt != sent_cnt) @(posedge i_clk);
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_data  <= rows;
        @(posedge i_clk);
        i_cfg_index <= CFG_COLUMN_COUNT;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rows_eff = (rows == '0) ? 1 : ((int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows));
        cols_eff = (cols == '0) ? 1 : ((int'(cols) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols));
        loads_since_restart = 0;
        shapes_run++;
    endtask

    // zero_tenths: chance out of ten that a load carries a signed zero
    task automatic random_beat(input int load_pct, input int zero_tenths, input bit noise);
        int                 pick;
        int                 built;
        logic [VALUE_W-1:0] bits;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        pick  = $urandom_range(0, 99);
        bits  = {$urandom, $urandom};
        row   = IDX_W'($urandom);
        col   = IDX_W'($urandom);
        built = loads_since_restart / cols_eff;
        if (built > rows_eff) built = rows_eff;
        if (pick < load_pct) begin
            if ($urandom_range(0, 9) < zero_tenths) bits = {bits[VALUE_W-1], 63'd0};
            else if ($urandom_range(0, 9) == 0) bits[62:52] = '0;
            send_beat(OP_LOAD, bits, row, col);
        end else if (pick < 93 || !noise) begin
            // mostly aim at finished rows and columns inside the shape
            if (built > 0 && $urandom_range(0, 99) < 80) row = IDX_W'($urandom_range(0, built - 1));
            if ($urandom_range(0, 99) < 85) col = IDX_W'($urandom_range(0, cols_eff - 1));
            send_beat(OP_LOOKUP, bits, row, col);
        end else if (pick < 97) begin
            send_beat(OP_RESTART, bits, row, col);
        end else begin
            send_beat(OP_UNUSED, bits, row, col);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing built yet at the reset shape
        send_beat(OP_LOOKUP, '0, 6'd0, 6'd0);

        // small 2x3 matrix with zeros of both signs, nan and denormals
        set_shape(7'd2, 7'd3);
        send_beat(OP_LOOKUP, '0, 6'd0, 6'd0);
        send_beat(OP_LOAD, 64'h0000_0000_0000_0000, 6'd0, 6'd0);
        send_beat(OP_LOAD, 64'h8000_0000_0000_0000, 6'd0, 6'd0);
        send_beat(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 6'd0);
        send_beat(OP_LOOKUP, '0, 6'd0, 6'd2);
        send_beat(OP_LOOKUP, '0, 6'd0, 6'd0);
        send_beat(OP_LOOKUP, '0, 6'd0, 6'd63);
        send_beat(OP_LOOKUP, '0, 6'd1, 6'd0);
        send_beat(OP_LOAD, 64'h7FF8_0000_0000_0001, 6'd0, 6'd0);
        send_beat(OP_LOAD, 64'h0000_0000_0000_0001, 6'd0, 6'd0);
        send_beat(OP_LOAD, 64'h8000_0000_0000_0001, 6'd0, 6'd0);
        send_beat(OP_LOAD, 64'h3FF0_0000_0000_0000, 6'd0, 6'd0);
        send_beat(OP_LOOKUP, '0, 6'd1, 6'd0);
        send_beat(OP_LOOKUP, '0, 6'd1, 6'd1);
        send_beat(OP_LOOKUP, '0, 6'd1, 6'd2);
        send_beat(OP_LOOKUP, '0, 6'd2, 6'd0);
        send_beat(OP_LOOKUP, '0, 6'd63, 6'd63);
        send_beat(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 6'd63);
        send_beat(OP_LOOKUP, '0, 6'd0, 6'd2);
        send_beat(OP_RESTART, '0, 6'd0, 6'd0);
        send_beat(OP_LOOKUP, '0, 6'd0, 6'd2);

        // a few full-width rows, mostly nonzero, then loads past completion and lookups
        send_gap_pct = 29;
        stall_pct    = 29;
        set_shape(7'(FILL_ROWS), 7'd64);
        while (loads_since_restart < FILL_ROWS * 64 + 4) random_beat(85, 1, 1'b0);
        repeat (30) random_beat(0, 0, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 50; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 50; end
                default: begin send_gap_pct = 29; stall_pct = 29; end
            endcase
            case (ph)
                0: set_shape(7'd0, 7'd0);
                1: set_shape(7'd127, 7'd127);
                2: set_shape(7'd64, 7'd1);
                3: set_shape(7'd1, 7'd64);
                4: set_shape(7'd1, 7'd1);
                5: set_shape(7'd64, 7'd64);
                11: set_shape(7'($urandom), 7'($urandom));
                default: set_shape(7'($urandom_range(1, 8)), 7'($urandom_range(1, 10)));
            endcase
            repeat (PHASE_BEATS) random_beat(55, 3, 1'b1);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d beats and took %0d answers over %0d matrix shapes",
                 sent_cnt, got_cnt, shapes_run);
        $display("shapes ran from 1x1 to 64x64, with loads sent past a finished build");
        if (errors == 0 && got_cnt == sent_cnt) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
